// File: rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// GIF block structure scanner package
// Phase codes, status codes, result word and helper functions.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int CountBitsDefault = 32;
  localparam int CntOutW          = 32;

  localparam logic [7:0] ByteTrailer   = 8'h3B;
  localparam logic [7:0] ByteExtIntro  = 8'h21;
  localparam logic [7:0] ByteImgSep    = 8'h2C;
  localparam logic [7:0] ByteLabelGce  = 8'hF9;
  localparam logic [7:0] ByteLabelApp  = 8'hFF;
  localparam logic [7:0] ByteLetterG   = 8'h47;
  localparam logic [7:0] ByteGceSize   = 8'h04;
  localparam logic [7:0] ByteAppIdSize = 8'h0B;
  localparam logic [7:0] ByteZero      = 8'h00;

  typedef enum logic [2:0] {
    StTrailer   = 3'd0,
    StEndInput  = 3'd1,
    StUnknown   = 3'd2,
    StEmptyApp  = 3'd3,
    StZeroSize  = 3'd4,
    StNoSig     = 3'd5
  } status_e;

  typedef enum logic [14:0] {
    PhHunt      = 15'b000000000000001,
    PhScreen    = 15'b000000000000010,
    PhGTable    = 15'b000000000000100,
    PhType      = 15'b000000000001000,
    PhLabel     = 15'b000000000010000,
    PhGceSize   = 15'b000000000100000,
    PhGceFields = 15'b000000001000000,
    PhGceSkip   = 15'b000000010000000,
    PhAppSize   = 15'b000000100000000,
    PhAppData   = 15'b000001000000000,
    PhSubSize   = 15'b000010000000000,
    PhSubData   = 15'b000100000000000,
    PhImgHead   = 15'b001000000000000,
    PhLTable    = 15'b010000000000000,
    PhImgLzw    = 15'b100000000000000
  } phase_e;

  typedef struct packed {
    logic [15:0]        screen_width;
    logic [15:0]        screen_height;
    logic [7:0]         aspect_code;
    logic [CntOutW-1:0] frame_count;
    logic [CntOutW-1:0] total_delay;
    status_e            status;
  } result_t;

  function automatic logic sig_match(input logic [2:0] pos, input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    case (pos)
      3'd0: hit = (b == 8'h47);
      3'd1: hit = (b == 8'h49);
      3'd2: hit = (b == 8'h46);
      3'd3: hit = (b == 8'h38);
      3'd4: hit = (b == 8'h37) || (b == 8'h39);
      3'd5: hit = (b == 8'h61);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [9:0] table_bytes(input logic [7:0] f);
    logic [3:0] sh;
    sh = {1'b0, f[2:0]} + 4'd1;
    return 10'd3 << sh;
  endfunction

endpackage

// File: rtl/gbs_out_skid.sv
// ----------------------------------------------------------------------------
// GIF scanner output stage
// Result register with one skid entry; stalls the input while the skid
// entry is occupied.
// ----------------------------------------------------------------------------
module gbs_out_skid
  import gbs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_word_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_word_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_word_q, skid_word_q;
  logic    pop;

  assign pop = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_word_q <= skid_word_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_word_q <= push_word_i;
      end else begin
        skid_word_q <= push_word_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: rtl/gif_block_structure_scanner.sv
// ----------------------------------------------------------------------------
// GIF block structure scanner
// Output: the summary word is registered at the accepting edge of the byte
//   ending the stream or block walk, into the result register or skid entry.
// Throughput: one byte per cycle unless stalled; the block-walk state
//   machine and counters update in the accepting cycle.
// Reset: all scan state cleared, signature hunt, scan_enabled set to 1.
// ----------------------------------------------------------------------------
module gif_block_structure_scanner
  import gbs_pkg::*;
#(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_scan_enabled_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] screen_width_o,
  output logic [15:0] screen_height_o,
  output logic [7:0]  aspect_code_o,
  output logic [31:0] frame_count_o,
  output logic [31:0] total_delay_o,
  output logic [2:0]  status_o
);

  localparam int WideW = (COUNT_BITS > CntOutW) ? COUNT_BITS : CntOutW;

  logic                  scan_en_q;
  phase_e                phase_q, phase_d;
  logic [2:0]            sig_pos_q, sig_pos_d;
  logic [9:0]            skip_q, skip_d;
  logic [3:0]            field_q, field_d;
  logic [15:0]           width_q, width_d;
  logic [15:0]           height_q, height_d;
  logic [7:0]            aspect_q, aspect_d;
  logic [7:0]            flags_q, flags_d;
  logic [7:0]            delay_low_q, delay_low_d;
  logic                  app_seen_q, app_seen_d;
  logic [COUNT_BITS-1:0] frames_q, frames_d;
  logic [COUNT_BITS-1:0] delay_q, delay_d;

  logic                  in_acc;
  logic                  emit;
  status_e               emit_status;
  logic [COUNT_BITS:0]   delay_add;
  logic [WideW-1:0]      frames_wide, delay_wide;
  result_t               res_word, out_word;
  logic                  skid_full;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign delay_add   = {1'b0, delay_q} + (COUNT_BITS+1)'({data_byte_i, delay_low_q});

  always_comb begin
    phase_d     = phase_q;
    sig_pos_d   = sig_pos_q;
    skip_d      = skip_q;
    field_d     = field_q;
    width_d     = width_q;
    height_d    = height_q;
    aspect_d    = aspect_q;
    flags_d     = flags_q;
    delay_low_d = delay_low_q;
    app_seen_d  = app_seen_q;
    frames_d    = frames_q;
    delay_d     = delay_q;
    emit        = 1'b0;
    emit_status = StTrailer;

    if (end_of_input_i) begin
      emit        = 1'b1;
      emit_status = (phase_q == PhHunt) ? StNoSig : StEndInput;
    end else begin
      case (phase_q)
        PhHunt: begin
          if (sig_match(sig_pos_q, data_byte_i)) begin
            if (sig_pos_q >= 3'd5) begin
              sig_pos_d = 3'd0;
              field_d   = 4'd0;
              phase_d   = PhScreen;
            end else begin
              sig_pos_d = sig_pos_q + 3'd1;
            end
          end else begin
            sig_pos_d = (data_byte_i == ByteLetterG) ? 3'd1 : 3'd0;
          end
        end
        PhScreen: begin
          case (field_q)
            4'd0: width_d[7:0]   = data_byte_i;
            4'd1: width_d[15:8]  = data_byte_i;
            4'd2: height_d[7:0]  = data_byte_i;
            4'd3: height_d[15:8] = data_byte_i;
            4'd4: flags_d        = data_byte_i;
            4'd5: ;
            default: aspect_d    = data_byte_i;
          endcase
          if (field_q < 4'd6) begin
            field_d = field_q + 4'd1;
          end else begin
            field_d = 4'd0;
            if (width_d == 16'd0 || height_d == 16'd0) begin
              emit        = 1'b1;
              emit_status = StZeroSize;
            end else if (!scan_en_q) begin
              emit        = 1'b1;
              emit_status = StTrailer;
            end else if (flags_q[7]) begin
              skip_d  = table_bytes(flags_q);
              phase_d = PhGTable;
            end else begin
              phase_d = PhType;
            end
          end
        end
        PhType: begin
          if (data_byte_i == ByteTrailer) begin
            emit        = 1'b1;
            emit_status = StTrailer;
          end else if (data_byte_i == ByteExtIntro) begin
            phase_d = PhLabel;
          end else if (data_byte_i == ByteImgSep) begin
            if (frames_q != '1) begin
              frames_d = frames_q + 1'b1;
            end
            field_d = 4'd0;
            phase_d = PhImgHead;
          end else begin
            emit        = 1'b1;
            emit_status = StUnknown;
          end
        end
        PhLabel: begin
          if (data_byte_i == ByteLabelGce) begin
            phase_d = PhGceSize;
          end else if (data_byte_i == ByteLabelApp) begin
            field_d    = 4'd0;
            app_seen_d = 1'b0;
            phase_d    = PhAppSize;
          end else begin
            phase_d = PhSubSize;
          end
        end
        PhGceSize: begin
          if (data_byte_i == ByteGceSize) begin
            field_d = 4'd0;
            phase_d = PhGceFields;
          end else if (data_byte_i == ByteZero) begin
            phase_d = PhSubSize;
          end else begin
            skip_d  = {2'b00, data_byte_i};
            phase_d = PhGceSkip;
          end
        end
        PhGceFields: begin
          if (field_q == 4'd1) begin
            delay_low_d = data_byte_i;
          end else if (field_q == 4'd2) begin
            delay_d = delay_add[COUNT_BITS] ? '1 : delay_add[COUNT_BITS-1:0];
          end
          if (field_q >= 4'd3) begin
            field_d = 4'd0;
            phase_d = PhSubSize;
          end else begin
            field_d = field_q + 4'd1;
          end
        end
        PhAppSize: begin
          if (data_byte_i == ByteZero) begin
            emit        = 1'b1;
            emit_status = StEmptyApp;
          end else begin
            if (field_q == 4'd0) begin
              app_seen_d = (data_byte_i == ByteAppIdSize);
            end
            skip_d  = {2'b00, data_byte_i};
            phase_d = PhAppData;
          end
        end
        PhSubSize: begin
          if (data_byte_i == ByteZero) begin
            phase_d = PhType;
          end else begin
            skip_d  = {2'b00, data_byte_i};
            phase_d = PhSubData;
          end
        end
        PhImgHead: begin
          if (field_q < 4'd8) begin
            field_d = field_q + 4'd1;
          end else begin
            field_d = 4'd0;
            flags_d = data_byte_i;
            if (data_byte_i[7]) begin
              skip_d  = table_bytes(data_byte_i);
              phase_d = PhLTable;
            end else begin
              phase_d = PhImgLzw;
            end
          end
        end
        PhImgLzw: begin
          phase_d = PhSubSize;
        end
        PhGTable, PhGceSkip, PhAppData, PhSubData, PhLTable: begin
          if (skip_q > 10'd1) begin
            skip_d = skip_q - 10'd1;
          end else begin
            skip_d = 10'd0;
            if (phase_q == PhGTable) begin
              phase_d = PhType;
            end else if (phase_q == PhLTable) begin
              phase_d = PhImgLzw;
            end else if (phase_q == PhAppData && field_q == 4'd0 && app_seen_q) begin
              field_d = 4'd1;
              phase_d = PhAppSize;
            end else begin
              field_d = 4'd0;
              phase_d = PhSubSize;
            end
          end
        end
        default: begin
          phase_d     = PhHunt;
          sig_pos_d   = 3'd0;
          skip_d      = 10'd0;
          field_d     = 4'd0;
          width_d     = 16'd0;
          height_d    = 16'd0;
          aspect_d    = 8'd0;
          flags_d     = 8'd0;
          delay_low_d = 8'd0;
          app_seen_d  = 1'b0;
          frames_d    = '0;
          delay_d     = '0;
        end
      endcase
    end

    frames_wide = WideW'(frames_q);
    delay_wide  = WideW'(delay_q);
    res_word.screen_width  = width_d;
    res_word.screen_height = height_d;
    res_word.aspect_code   = aspect_d;
    res_word.frame_count   = (frames_wide > WideW'({CntOutW{1'b1}})) ?
                             {CntOutW{1'b1}} : frames_wide[CntOutW-1:0];
    res_word.total_delay   = (delay_wide > WideW'({CntOutW{1'b1}})) ?
                             {CntOutW{1'b1}} : delay_wide[CntOutW-1:0];
    res_word.status        = emit_status;

    if (emit) begin
      phase_d     = PhHunt;
      sig_pos_d   = 3'd0;
      skip_d      = 10'd0;
      field_d     = 4'd0;
      width_d     = 16'd0;
      height_d    = 16'd0;
      aspect_d    = 8'd0;
      flags_d     = 8'd0;
      delay_low_d = 8'd0;
      app_seen_d  = 1'b0;
      frames_d    = '0;
      delay_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scan_en_q <= cfg_scan_enabled_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      sig_pos_q   <= 3'd0;
      skip_q      <= 10'd0;
      field_q     <= 4'd0;
      width_q     <= 16'd0;
      height_q    <= 16'd0;
      aspect_q    <= 8'd0;
      flags_q     <= 8'd0;
      delay_low_q <= 8'd0;
      app_seen_q  <= 1'b0;
      frames_q    <= '0;
      delay_q     <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      sig_pos_q   <= sig_pos_d;
      skip_q      <= skip_d;
      field_q     <= field_d;
      width_q     <= width_d;
      height_q    <= height_d;
      aspect_q    <= aspect_d;
      flags_q     <= flags_d;
      delay_low_q <= delay_low_d;
      app_seen_q  <= app_seen_d;
      frames_q    <= frames_d;
      delay_q     <= delay_d;
    end
  end

  gbs_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc & emit),
    .push_word_i (res_word),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word)
  );

  assign in_stall_o      = skid_full;
  assign screen_width_o  = out_word.screen_width;
  assign screen_height_o = out_word.screen_height;
  assign aspect_code_o   = out_word.aspect_code;
  assign frame_count_o   = out_word.frame_count;
  assign total_delay_o   = out_word.total_delay;
  assign status_o        = out_word.status;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result word waiting");

  a_sig_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sig_pos_q <= 3'd5)
    else $error("signature position out of range");

  a_skip_only_in_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q != 10'd0) |-> (phase_q == PhGTable || phase_q == PhGceSkip ||
                           phase_q == PhAppData || phase_q == PhSubData ||
                           phase_q == PhLTable))
    else $error("skip count left outside a skip phase");

  a_hunt_counts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHunt) |-> (frames_q == '0 && delay_q == '0))
    else $error("counters not cleared during signature hunt");

endmodule
